// ----- design/cbox_pkg.sv -----
// Shared types and constants for the RGB to HSL colour box block.
package cbox_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int RUN_LENGTH = 5;

   // numerator width of the two divisions (360 * 255 needs 17 bits)
   localparam int NUM_W  = 18;
   localparam int DEN_W  = 9;
   localparam int STEP_W = $clog2(NUM_W);
   localparam int CFG_AW = 5;

   localparam logic [DEN_W-1:0] LIGHT_DEN = DEN_W'(510);

   // lightness = 360 * sum / 510 = 12 * sum / 17, taken as (12 * sum * 7711) >> 17;
   // exact for 12 * sum up to 6120
   localparam logic [12:0] LIGHT_RECIP = 13'd7711;
   localparam int          LIGHT_SHIFT = 17;

   // register indexes
   localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] REG_TARGET_HUE   = 3'd2;
   localparam logic [2:0] REG_TARGET_SAT   = 3'd3;
   localparam logic [2:0] REG_TARGET_LIGHT = 3'd4;
   localparam logic [2:0] REG_HUE_TOL      = 3'd5;
   localparam logic [2:0] REG_SAT_TOL      = 3'd6;
   localparam logic [2:0] REG_LIGHT_TOL    = 3'd7;

   typedef struct packed {
      logic [12:0] frame_width;
      logic [12:0] frame_height;
      logic [8:0]  target_hue;
      logic [8:0]  target_sat;
      logic [8:0]  target_light;
      logic [8:0]  hue_tol;
      logic [8:0]  sat_tol;
      logic [8:0]  light_tol;
   } cfg_type;

   // one classified request waiting for the dividers
   typedef struct packed {
      logic             gray;
      logic [NUM_W-1:0] hue_num;
      logic [DEN_W-1:0] hue_den;
      logic [NUM_W-1:0] sat_num;
      logic [DEN_W-1:0] sat_den;
      logic [8:0]       light;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

// ----- design/cbox_if.sv -----
// Valid/ready channel interfaces for pixel requests and results.
interface cbox_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   modport source (output valid, red, green, blue, input ready);
   modport sink (input valid, red, green, blue, output ready);
endinterface

interface cbox_rsp_if;
   logic        valid;
   logic        ready;
   logic [8:0]  hue;
   logic [8:0]  saturation;
   logic [8:0]  lightness;
   logic        color_match;
   logic        run_reached;
   logic        frame_done;
   logic [12:0] box_left;
   logic [12:0] box_top;
   logic [11:0] box_right;
   logic [11:0] box_bottom;
   logic        box_found;
   modport source (output valid, hue, saturation, lightness, color_match, run_reached,
                   frame_done, box_left, box_top, box_right, box_bottom, box_found,
                   input ready);
   modport sink (input valid, hue, saturation, lightness, color_match, run_reached,
                 frame_done, box_left, box_top, box_right, box_bottom, box_found,
                 output ready);
endinterface

// ----- design/rgb_to_hsl_color_box.sv -----
// Top level: register port, front end, request queue and divider back end.
// The result register loads after the request is accepted (load, 18 divider steps,
// commit) when the back end is idle.
// The back end works on one request at a time, through the 18-step bit-serial dividers.
// The front end and a two-entry queue take requests while the back end divides.
// Synchronous active-high reset clears the queue, frame position, run count and box;
// registers return to their documented defaults.
module rgb_to_hsl_color_box (
   input  logic                         clock,
   input  logic                         reset,
   cbox_req_if.sink                     req_if,
   cbox_rsp_if.source                   rsp_if,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [cbox_pkg::CFG_AW-1:0]  csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   cbox_pkg::cfg_type cfg_ff;
   cbox_pkg::job_type front_job, queue_job;
   logic push, full, pop, not_empty, cfg_wr;
   logic [2:0] reg_sel;

   assign csr_pready = 1'b1;
   assign cfg_wr  = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel = csr_paddr[4:2];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= 13'd640;
         cfg_ff.frame_height <= 13'd480;
         cfg_ff.target_hue   <= 9'd0;
         cfg_ff.target_sat   <= 9'd0;
         cfg_ff.target_light <= 9'd0;
         cfg_ff.hue_tol      <= 9'd30;
         cfg_ff.sat_tol      <= 9'd100;
         cfg_ff.light_tol    <= 9'd360;
      end else if (cfg_wr && csr_paddr[1:0] == 2'd0) begin
         unique case (reg_sel)
            cbox_pkg::REG_FRAME_WIDTH:  cfg_ff.frame_width  <= csr_pwdata[12:0];
            cbox_pkg::REG_FRAME_HEIGHT: cfg_ff.frame_height <= csr_pwdata[12:0];
            cbox_pkg::REG_TARGET_HUE:   cfg_ff.target_hue   <= csr_pwdata[8:0];
            cbox_pkg::REG_TARGET_SAT:   cfg_ff.target_sat   <= csr_pwdata[8:0];
            cbox_pkg::REG_TARGET_LIGHT: cfg_ff.target_light <= csr_pwdata[8:0];
            cbox_pkg::REG_HUE_TOL:      cfg_ff.hue_tol      <= csr_pwdata[8:0];
            cbox_pkg::REG_SAT_TOL:      cfg_ff.sat_tol      <= csr_pwdata[8:0];
            cbox_pkg::REG_LIGHT_TOL:    cfg_ff.light_tol    <= csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   // register read-back
   always_comb begin
      unique case (reg_sel)
         cbox_pkg::REG_FRAME_WIDTH:  csr_prdata = 32'(cfg_ff.frame_width);
         cbox_pkg::REG_FRAME_HEIGHT: csr_prdata = 32'(cfg_ff.frame_height);
         cbox_pkg::REG_TARGET_HUE:   csr_prdata = 32'(cfg_ff.target_hue);
         cbox_pkg::REG_TARGET_SAT:   csr_prdata = 32'(cfg_ff.target_sat);
         cbox_pkg::REG_TARGET_LIGHT: csr_prdata = 32'(cfg_ff.target_light);
         cbox_pkg::REG_HUE_TOL:      csr_prdata = 32'(cfg_ff.hue_tol);
         cbox_pkg::REG_SAT_TOL:      csr_prdata = 32'(cfg_ff.sat_tol);
         cbox_pkg::REG_LIGHT_TOL:    csr_prdata = 32'(cfg_ff.light_tol);
         default:                    csr_prdata = 32'd0;
      endcase
   end

   cbox_front u_front (
      .in_valid (req_if.valid),
      .in_ready (req_if.ready),
      .red      (req_if.red),
      .green    (req_if.green),
      .blue     (req_if.blue),
      .push     (push),
      .job      (front_job),
      .full     (full)
   );

   cbox_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (front_job),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_job   (queue_job)
   );

   cbox_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (not_empty),
      .job       (queue_job),
      .job_pop   (pop),
      .rsp       (rsp_if)
   );

endmodule

// ----- design/cbox_front.sv -----
// Front end: takes a pixel and forms the numerators and divisors of its HSL values.
module cbox_front (
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [7:0]         red,
   input  logic [7:0]         green,
   input  logic [7:0]         blue,
   output logic               push,
   output cbox_pkg::job_type  job,
   input  logic               full
);

   logic [7:0] mx, mn, d;
   logic [8:0] sum;
   logic [cbox_pkg::NUM_W-1:0] d360, d120, d240, r60, g60, b60;
   logic [12:0] light12;
   logic [25:0] light_prod;

   assign in_ready = !full;
   assign push     = in_valid && !full;

   // max, min and spread
   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      d   = mx - mn;
      sum = {1'b0, mx} + {1'b0, mn};
   end

   always_comb begin
      d360 = cbox_pkg::NUM_W'(d) * cbox_pkg::NUM_W'(360);
      d120 = cbox_pkg::NUM_W'(d) * cbox_pkg::NUM_W'(120);
      d240 = cbox_pkg::NUM_W'(d) * cbox_pkg::NUM_W'(240);
      r60  = cbox_pkg::NUM_W'(red) * cbox_pkg::NUM_W'(60);
      g60  = cbox_pkg::NUM_W'(green) * cbox_pkg::NUM_W'(60);
      b60  = cbox_pkg::NUM_W'(blue) * cbox_pkg::NUM_W'(60);
   end

   // lightness by reciprocal multiply of 12 * sum
   always_comb begin
      light12    = {1'b0, sum, 3'b000} + {2'b00, sum, 2'b00};
      light_prod = 26'(light12) * 26'(cbox_pkg::LIGHT_RECIP);
   end

   // numerators and divisors
   always_comb begin
      job.gray      = (d == 8'd0);
      job.hue_den   = {1'b0, d};
      job.light     = light_prod[cbox_pkg::LIGHT_SHIFT +: 9];
      job.sat_num   = d360;
      job.sat_den   = (sum > 9'd255) ? (cbox_pkg::LIGHT_DEN - sum) : sum;
      if (mx == red) begin
         job.hue_num = (green < blue) ? (d360 + g60 - b60) : (g60 - b60);
      end else if (mx == green) begin
         job.hue_num = d120 + b60 - r60;
      end else begin
         job.hue_num = d240 + r60 - g60;
      end
   end

endmodule

// ----- design/cbox_queue.sv -----
// Two-entry queue between the front end and the divider back end.
module cbox_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cbox_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output cbox_pkg::job_type pop_job
);

   cbox_pkg::job_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_job   = slot_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

// ----- design/cbox_back.sv -----
// Back end: bit-serial dividers, colour match, run count, frame position and box.
module cbox_back (
   input  logic              clock,
   input  logic              reset,
   input  cbox_pkg::cfg_type cfg,
   input  logic              job_valid,
   input  cbox_pkg::job_type job,
   output logic              job_pop,
   cbox_rsp_if.source        rsp
);

   cbox_pkg::back_state_type state_ff, state_in;

   // lane 0 hue, lane 1 saturation
   logic [cbox_pkg::NUM_W-1:0]  num_ff [2];
   logic [cbox_pkg::NUM_W-1:0]  quo_ff [2];
   logic [cbox_pkg::DEN_W-1:0]  den_ff [2];
   logic [cbox_pkg::DEN_W-1:0]  rem_ff [2];
   logic [cbox_pkg::DEN_W-1:0]  rem_in [2];
   logic [1:0]                  qbit;
   logic [cbox_pkg::STEP_W-1:0] step_ff;
   logic                        gray_ff;
   logic [8:0]                  light_ff;

   logic [11:0] column_ff, row_ff;
   logic [2:0]  run_ff;
   logic [12:0] left_ff, top_ff;
   logic [11:0] right_ff, bottom_ff;
   logic        found_ff;
   logic        out_valid_ff;

   logic load, steping, last_step, commit;

   // one restoring step per lane
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         logic [cbox_pkg::DEN_W:0] trial;
         trial   = {rem_ff[i], num_ff[i][cbox_pkg::NUM_W-1]};
         qbit[i] = (trial >= {1'b0, den_ff[i]});
         rem_in[i] = qbit[i] ? cbox_pkg::DEN_W'(trial - {1'b0, den_ff[i]})
                             : trial[cbox_pkg::DEN_W-1:0];
      end
   end

   assign last_step = (step_ff == cbox_pkg::STEP_W'(cbox_pkg::NUM_W - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cbox_pkg::BK_IDLE: if (job_valid) state_in = cbox_pkg::BK_DIV;
         cbox_pkg::BK_DIV:  if (last_step) state_in = cbox_pkg::BK_DONE;
         cbox_pkg::BK_DONE: if (!out_valid_ff || rsp.ready) state_in = cbox_pkg::BK_IDLE;
         default:           state_in = cbox_pkg::BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      load    = 1'b0;
      steping = 1'b0;
      commit  = 1'b0;
      unique case (state_ff)
         cbox_pkg::BK_IDLE: load = job_valid;
         cbox_pkg::BK_DIV:  steping = 1'b1;
         cbox_pkg::BK_DONE: commit = !out_valid_ff || rsp.ready;
         default: ;
      endcase
   end

   assign job_pop = load;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= cbox_pkg::BK_IDLE;
      else state_ff <= state_in;
   end

   // divider datapath
   always_ff @(posedge clock) begin
      if (load) begin
         num_ff[0] <= job.hue_num;
         num_ff[1] <= job.sat_num;
         den_ff[0] <= job.gray ? 9'd1 : job.hue_den;
         den_ff[1] <= job.gray ? 9'd1 : job.sat_den;
         gray_ff   <= job.gray;
         light_ff  <= job.light;
         step_ff   <= '0;
         for (int i = 0; i < 2; i++) begin
            rem_ff[i] <= '0;
            quo_ff[i] <= '0;
         end
      end else if (steping) begin
         step_ff <= step_ff + 1'b1;
         for (int i = 0; i < 2; i++) begin
            rem_ff[i] <= rem_in[i];
            num_ff[i] <= {num_ff[i][cbox_pkg::NUM_W-2:0], 1'b0};
            quo_ff[i] <= {quo_ff[i][cbox_pkg::NUM_W-2:0], qbit[i]};
         end
      end
   end

   // per-pixel evaluation of match, run, position and box
   logic [12:0] w_eff, h_eff;
   logic [8:0]  hue_v, sat_v, light_v;
   logic [9:0]  dh, ds, dl;
   logic        match, reached, first, last_col, done;
   logic [2:0]  run_in;
   logic [12:0] left_in, top_in;
   logic [11:0] right_in, bottom_in;
   logic        found_in;

   always_comb begin
      if (cfg.frame_width == 13'd0) w_eff = 13'd1;
      else if (cfg.frame_width > 13'(cbox_pkg::MAX_WIDTH)) w_eff = 13'(cbox_pkg::MAX_WIDTH);
      else w_eff = cfg.frame_width;
      if (cfg.frame_height == 13'd0) h_eff = 13'd1;
      else if (cfg.frame_height > 13'(cbox_pkg::MAX_HEIGHT)) h_eff = 13'(cbox_pkg::MAX_HEIGHT);
      else h_eff = cfg.frame_height;

      hue_v   = gray_ff ? 9'd0 : quo_ff[0][8:0];
      sat_v   = gray_ff ? 9'd0 : quo_ff[1][8:0];
      light_v = light_ff;
      dh = (hue_v > cfg.target_hue) ? {1'b0, hue_v} - {1'b0, cfg.target_hue}
                                    : {1'b0, cfg.target_hue} - {1'b0, hue_v};
      ds = (sat_v > cfg.target_sat) ? {1'b0, sat_v} - {1'b0, cfg.target_sat}
                                    : {1'b0, cfg.target_sat} - {1'b0, sat_v};
      dl = (light_v > cfg.target_light) ? {1'b0, light_v} - {1'b0, cfg.target_light}
                                        : {1'b0, cfg.target_light} - {1'b0, light_v};
      match = (dh < {1'b0, cfg.hue_tol}) && (ds < {1'b0, cfg.sat_tol})
              && (dl < {1'b0, cfg.light_tol});

      first     = (column_ff == 12'd0) && (row_ff == 12'd0);
      left_in   = first ? w_eff : left_ff;
      top_in    = first ? h_eff : top_ff;
      right_in  = first ? 12'd0 : right_ff;
      bottom_in = first ? 12'd0 : bottom_ff;
      found_in  = first ? 1'b0 : found_ff;
      run_in    = (column_ff == 12'd0) ? 3'd0 : run_ff;
      reached   = 1'b0;

      if (match) begin
         if (run_in != 3'd7) run_in = run_in + 3'd1;
         if (run_in >= 3'(cbox_pkg::RUN_LENGTH)) begin
            reached  = 1'b1;
            found_in = 1'b1;
            if ({1'b0, column_ff} < left_in) left_in = {1'b0, column_ff};
            if (column_ff > right_in) right_in = column_ff;
            if ({1'b0, row_ff} < top_in) top_in = {1'b0, row_ff};
            if (row_ff > bottom_in) bottom_in = row_ff;
         end
      end else begin
         run_in = 3'd0;
      end

      last_col = ({1'b0, column_ff} + 13'd1) >= w_eff;
      done     = last_col && (({1'b0, row_ff} + 13'd1) >= h_eff);
   end

   // frame tracking state, updated when a result is committed
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
         run_ff    <= '0;
         left_ff   <= 13'd640;
         top_ff    <= 13'd480;
         right_ff  <= '0;
         bottom_ff <= '0;
         found_ff  <= 1'b0;
      end else if (commit) begin
         run_ff    <= run_in;
         left_ff   <= left_in;
         top_ff    <= top_in;
         right_ff  <= right_in;
         bottom_ff <= bottom_in;
         found_ff  <= found_in;
         if (last_col) begin
            column_ff <= '0;
            row_ff    <= done ? 12'd0 : row_ff + 12'd1;
         end else begin
            column_ff <= column_ff + 12'd1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (commit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp.hue         <= hue_v;
         rsp.saturation  <= sat_v;
         rsp.lightness   <= light_v;
         rsp.color_match <= match;
         rsp.run_reached <= reached;
         rsp.frame_done  <= done;
         rsp.box_left    <= done ? left_in : 13'd0;
         rsp.box_top     <= done ? top_in : 13'd0;
         rsp.box_right   <= done ? right_in : 12'd0;
         rsp.box_bottom  <= done ? bottom_in : 12'd0;
         rsp.box_found   <= done ? found_in : 1'b0;
      end
   end

   assign rsp.valid = out_valid_ff;

endmodule
